// File: design/bmrs_pkg.sv
// ----------------------------------------------------------------------------
// bmrs_pkg
// Shared widths and request codes for the bitmap range set and find block.
// ----------------------------------------------------------------------------
package bmrs_pkg;

	localparam int unsigned BIT_FIELD_W = 13;
	localparam int unsigned FOUND_IDX_W = 12;

	typedef enum logic {
		ACT_CHANGE = 1'b0,
		ACT_FIND   = 1'b1
	} action_t;

endpackage

// File: design/bmrs_ram.sv
// ----------------------------------------------------------------------------
// bmrs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bmrs_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/bitmap_range_set_find_first.sv
// ----------------------------------------------------------------------------
// bitmap_range_set_find_first
// Bitmap of MAP_BITS bits kept in a word-wide RAM, with range set/clear and
// find-first-bit requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its result shows on
// found, found_index and range_error for one cycle with done high; the
// receiver cannot stall it. A request walks the storage words of its range
// through one RAM read port and one write port, one word per cycle, with a
// read-modify-write of each word; a find stops at the word holding the first
// match, and an empty, empty-search or out-of-range request goes from idle
// straight to the done state without reading the RAM. busy falls in the cycle
// done is high, so the next request may follow at once. Every word has a valid
// bit that reset clears, so the bitmap reads all zero right after reset with
// no clearing pass. WORD_BITS must be a power of two.
// ----------------------------------------------------------------------------
module bitmap_range_set_find_first
	import bmrs_pkg::*;
#(
	parameter int unsigned MAP_BITS  = 4096,
	parameter int unsigned WORD_BITS = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   action,
	input  logic [BIT_FIELD_W-1:0] start_bit,
	input  logic [BIT_FIELD_W-1:0] bit_count,
	input  logic [BIT_FIELD_W-1:0] search_end,
	input  logic                   bit_value,
	output logic                   done,
	output logic                   found,
	output logic [FOUND_IDX_W-1:0] found_index,
	output logic                   range_error
);

	localparam int unsigned STORE_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned WORD_SHIFT  = $clog2(WORD_BITS);
	localparam int unsigned WADDR       = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
	localparam int unsigned CMP_W       = 20;
	localparam int unsigned IDX_W       = WADDR + WORD_SHIFT;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DONE
	} state_t;

	state_t                 state_q;
	logic                   act_q;
	logic                   val_q;
	logic [WADDR-1:0]       first_w_q;
	logic [WADDR-1:0]       last_w_q;
	logic [WORD_SHIFT-1:0]  lo_off_q;
	logic [WORD_SHIFT-1:0]  hi_off_q;
	logic [WADDR-1:0]       rd_w_q;
	logic                   issue_q;
	logic                   err_q;
	logic                   hit_q;
	logic [WORD_BITS-1:0]   hits_q;
	logic [WADDR-1:0]       base_q;

	logic                   vld_s1;
	logic [WADDR-1:0]       w_s1;
	logic                   first_s1;
	logic                   last_s1;
	logic                   word_vld_s1;

	logic                   done_q;
	logic                   found_q;
	logic [FOUND_IDX_W-1:0] found_index_q;
	logic                   range_error_q;

	logic [STORE_WORDS-1:0] word_vld_q;

	logic [CMP_W-1:0]       start_ext;
	logic [CMP_W-1:0]       send_ext;
	logic [CMP_W-1:0]       sum_ext;
	logic [CMP_W-1:0]       hi_ext;
	logic [CMP_W-1:0]       last_ext;
	logic                   req_err;
	logic                   req_empty;

	logic [WORD_BITS-1:0]   rdata;
	logic [WORD_BITS-1:0]   cur_word;
	logic [WORD_BITS-1:0]   lo_mask;
	logic [WORD_BITS-1:0]   hi_mask;
	logic [WORD_BITS-1:0]   span;
	logic [WORD_BITS-1:0]   hits;
	logic [WORD_BITS-1:0]   wdata;
	logic                   we;
	logic [WORD_SHIFT-1:0]  hit_pos;
	logic [IDX_W-1:0]       hit_idx;

	localparam logic [WORD_BITS-1:0] ALL_ONES = '1;

	function automatic logic [WORD_SHIFT-1:0] first_one(input logic [WORD_BITS-1:0] v);
		logic [WORD_SHIFT-1:0] k;
		k = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				k = WORD_SHIFT'(i);
			end
		end
		return k;
	endfunction

	// request decode
	always_comb begin
		start_ext = CMP_W'(start_bit);
		send_ext  = CMP_W'(search_end);
		sum_ext   = CMP_W'(start_bit) + CMP_W'(bit_count);
		if (action == ACT_CHANGE) begin
			req_err   = (bit_count == '0) || (sum_ext > CMP_W'(MAP_BITS));
			req_empty = 1'b0;
			hi_ext    = sum_ext;
		end else begin
			req_err   = (start_ext > send_ext) || (send_ext > CMP_W'(MAP_BITS));
			req_empty = (start_ext == send_ext);
			hi_ext    = send_ext;
		end
		last_ext = hi_ext - CMP_W'(1);
	end

	// word read back, masked and merged
	always_comb begin
		cur_word = rdata & {WORD_BITS{word_vld_s1}};
		lo_mask  = first_s1 ? (ALL_ONES << lo_off_q) : ALL_ONES;
		hi_mask  = last_s1 ? (ALL_ONES >> (WORD_SHIFT'(WORD_BITS - 1) - hi_off_q)) : ALL_ONES;
		span     = lo_mask & hi_mask;
		hits     = (val_q ? cur_word : ~cur_word) & span;
		wdata    = val_q ? (cur_word | span) : (cur_word & ~span);
		we       = vld_s1 && (state_q == S_RUN) && (act_q == ACT_CHANGE);
		hit_pos  = first_one(hits_q);
		hit_idx  = {base_q, hit_pos};
	end

	bmrs_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(STORE_WORDS)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(w_s1),
		.wdata(wdata),
		.raddr(rd_w_q),
		.rdata(rdata)
	);

	// per-word valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_vld_q  <= '0;
			word_vld_s1 <= 1'b0;
		end else begin
			if (we) begin
				word_vld_q[w_s1] <= 1'b1;
			end
			word_vld_s1 <= word_vld_q[rd_w_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			issue_q       <= 1'b0;
			vld_s1        <= 1'b0;
			done_q        <= 1'b0;
			found_q       <= 1'b0;
			found_index_q <= '0;
			range_error_q <= 1'b0;
			hit_q         <= 1'b0;
			err_q         <= 1'b0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						act_q     <= action;
						val_q     <= bit_value;
						first_w_q <= start_ext[WORD_SHIFT +: WADDR];
						rd_w_q    <= start_ext[WORD_SHIFT +: WADDR];
						last_w_q  <= last_ext[WORD_SHIFT +: WADDR];
						lo_off_q  <= start_bit[WORD_SHIFT-1:0];
						hi_off_q  <= last_ext[WORD_SHIFT-1:0];
						hit_q     <= 1'b0;
						err_q     <= req_err;
						if (req_err || req_empty) begin
							state_q <= S_DONE;
						end else begin
							issue_q <= 1'b1;
							state_q <= S_RUN;
						end
					end
				end
				S_RUN: begin
					if (issue_q) begin
						vld_s1   <= 1'b1;
						w_s1     <= rd_w_q;
						first_s1 <= (rd_w_q == first_w_q);
						last_s1  <= (rd_w_q == last_w_q);
						rd_w_q   <= rd_w_q + WADDR'(1);
						if (rd_w_q == last_w_q) begin
							issue_q <= 1'b0;
						end
					end
					if (vld_s1) begin
						if ((act_q == ACT_FIND) && (hits != '0)) begin
							hit_q   <= 1'b1;
							hits_q  <= hits;
							base_q  <= w_s1;
							issue_q <= 1'b0;
							state_q <= S_DONE;
						end else if (last_s1) begin
							issue_q <= 1'b0;
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					done_q        <= 1'b1;
					found_q       <= hit_q;
					found_index_q <= hit_q ? FOUND_IDX_W'(hit_idx) : '0;
					range_error_q <= err_q;
					state_q       <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign found       = found_q;
	assign found_index = found_index_q;
	assign range_error = range_error_q;

endmodule

// File: verif/tb_bitmap_range_set_find_first.sv
// ----------------------------------------------------------------------------
// tb_bitmap_range_set_find_first
// Self-checking bench for the bitmap range set and find-first block. A bit-level
// mirror of the bitmap predicts each result and a monitor compares each done
// strobe against the oldest prediction. Directed cases cover empty maps, word
// edges and every range error. Random traffic then runs under several sender
// idle rates.
// ----------------------------------------------------------------------------
module tb_bitmap_range_set_find_first;
	import bmrs_pkg::*;

	localparam int unsigned MAP_W    = 4096;
	localparam int unsigned DRAIN_CY = 80;

	typedef struct packed {
		logic                   found;
		logic [FOUND_IDX_W-1:0] index;
		logic                   range_error;
	} outcome_t;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	action_t                action;
	logic [BIT_FIELD_W-1:0] start_bit;
	logic [BIT_FIELD_W-1:0] bit_count;
	logic [BIT_FIELD_W-1:0] search_end;
	logic                   bit_value;
	logic                   done;
	logic                   found;
	logic [FOUND_IDX_W-1:0] found_index;
	logic                   range_error;

	logic [MAP_W-1:0] bitmap_mirror;
	outcome_t         pending_outcomes[$];
	int unsigned      mismatch_count;
	int unsigned      send_idle_pct;

	bitmap_range_set_find_first i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.start_bit   (start_bit),
		.bit_count   (bit_count),
		.search_end  (search_end),
		.bit_value   (bit_value),
		.done        (done),
		.found       (found),
		.found_index (found_index),
		.range_error (range_error)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	// updates the mirror for a change and scans it for a find
	function automatic outcome_t apply_request(input action_t act,
			input int unsigned s, input int unsigned c, input int unsigned e,
			input logic val);
		outcome_t res;
		res = '0;
		if (act == ACT_CHANGE) begin
			if (c == 0 || s + c > MAP_W) begin
				res.range_error = 1'b1;
			end else begin
				for (int unsigned i = s; i < s + c; i++) bitmap_mirror[i] = val;
			end
		end else begin
			if (s > e || e > MAP_W) begin
				res.range_error = 1'b1;
			end else begin
				for (int unsigned i = s; i < e; i++) begin
					if (bitmap_mirror[i] == val) begin
						res.found = 1'b1;
						res.index = FOUND_IDX_W'(i);
						break;
					end
				end
			end
		end
		return res;
	endfunction

	always @(posedge clk) begin
		outcome_t exp;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				exp = pending_outcomes.pop_front();
				if (found !== exp.found)
					report_mismatch($sformatf("found exp %0d got %0d", exp.found, found));
				if (found_index !== exp.index)
					report_mismatch($sformatf("found_index exp %0d got %0d",
						exp.index, found_index));
				if (range_error !== exp.range_error)
					report_mismatch($sformatf("range_error exp %0d got %0d",
						exp.range_error, range_error));
			end
		end
	end

	task automatic send_request(input action_t act, input int unsigned s,
			input int unsigned c, input int unsigned e, input logic val);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start      <= 1'b1;
		action     <= act;
		start_bit  <= BIT_FIELD_W'(s);
		bit_count  <= BIT_FIELD_W'(c);
		search_end <= BIT_FIELD_W'(e);
		bit_value  <= val;
		do @(posedge clk); while (busy);
		pending_outcomes.push_back(apply_request(act, 32'(BIT_FIELD_W'(s)),
			32'(BIT_FIELD_W'(c)), 32'(BIT_FIELD_W'(e)), val));
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
	endtask

	task automatic test_empty_map();
		send_request(ACT_FIND, 0, 0, MAP_W, 1'b1);
		send_request(ACT_FIND, 0, 0, MAP_W, 1'b0);
		send_request(ACT_FIND, 0, 0, 0, 1'b0);
		send_request(ACT_FIND, MAP_W, 0, MAP_W, 1'b0);
	endtask

	task automatic test_range_errors();
		send_request(ACT_CHANGE, 10, 0, 0, 1'b1);
		send_request(ACT_CHANGE, 4000, 100, 0, 1'b1);
		send_request(ACT_CHANGE, 8191, 8191, 8191, 1'b1);
		send_request(ACT_FIND, 100, 0, 50, 1'b0);
		send_request(ACT_FIND, 0, 0, MAP_W + 1, 1'b0);
		send_request(ACT_FIND, 8191, 8191, 8191, 1'b1);
		send_request(ACT_FIND, 0, 0, MAP_W, 1'b1);
	endtask

	task automatic test_word_edges();
		send_request(ACT_CHANGE, 0, MAP_W, 0, 1'b1);
		send_request(ACT_FIND, 0, 0, MAP_W, 1'b0);
		send_request(ACT_CHANGE, 63, 2, 0, 1'b0);
		send_request(ACT_FIND, 0, 0, MAP_W, 1'b0);
		send_request(ACT_FIND, 63, 0, MAP_W, 1'b1);
		send_request(ACT_FIND, 64, 0, 64, 1'b0);
		send_request(ACT_CHANGE, MAP_W - 1, 1, 0, 1'b0);
		send_request(ACT_FIND, 4000, 0, MAP_W, 1'b0);
		send_request(ACT_CHANGE, 0, MAP_W, 0, 1'b0);
		send_request(ACT_FIND, 0, 0, MAP_W, 1'b1);
		send_request(ACT_CHANGE, 130, 1000, 0, 1'b1);
		send_request(ACT_FIND, 0, 0, MAP_W, 1'b1);
	endtask

	task automatic test_random_requests(input int unsigned n_items,
			input int unsigned idle_pct);
		int unsigned r, s, c, e, room;
		send_idle_pct = idle_pct;
		repeat (n_items) begin
			r = $urandom_range(99);
			if ($urandom_range(1)) begin
				if (r < 6) begin
					s = $urandom_range(8191);
					c = $urandom_range(8191);
				end else if (r < 10) begin
					s = $urandom_range(MAP_W);
					c = 0;
				end else if (r < 14) begin
					s = $urandom_range(MAP_W - 1, 1);
					c = $urandom_range(MAP_W, MAP_W - s + 1);
				end else begin
					s = $urandom_range(MAP_W - 1);
					room = MAP_W - s;
					c = (r < 88) ? $urandom_range(room < 80 ? room : 80, 1)
						: $urandom_range(room, 1);
				end
				send_request(ACT_CHANGE, s, c, $urandom_range(8191),
					1'($urandom_range(1)));
			end else begin
				if (r < 6) begin
					s = $urandom_range(8191);
					e = $urandom_range(8191);
				end else if (r < 10) begin
					s = $urandom_range(MAP_W, 1);
					e = $urandom_range(s - 1);
				end else if (r < 14) begin
					s = $urandom_range(MAP_W);
					e = s;
				end else begin
					s = $urandom_range(MAP_W - 1);
					room = MAP_W - s;
					e = (r < 80) ? s + $urandom_range(room < 200 ? room : 200, 1)
						: $urandom_range(MAP_W, s + 1);
				end
				send_request(ACT_FIND, s, $urandom_range(8191), e,
					1'($urandom_range(1)));
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		start          = 1'b0;
		action         = ACT_CHANGE;
		start_bit      = '0;
		bit_count      = '0;
		search_end     = '0;
		bit_value      = 1'b0;
		bitmap_mirror  = '0;
		mismatch_count = 0;
		send_idle_pct  = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		test_empty_map();
		test_range_errors();
		test_word_edges();
		wait_for_results();
		test_random_requests(500, 26);
		wait_for_results();
		test_random_requests(500, 45);
		wait_for_results();
		test_random_requests(450, 0);
		wait_for_results();
		repeat (DRAIN_CY) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
design/bmrs_pkg.sv
design/bmrs_ram.sv
design/bitmap_range_set_find_first.sv
verif/tb_bitmap_range_set_find_first.sv
